// ===== hw/rtl/dad_pkg.sv =====
// Package for date_add_days: calendar constants, month table, control types.
package dad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned RUN_W   = 17;   // day plus count, before normalizing

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

  // Divide by 100 through a reciprocal: (y * 5243) >> 19 is exact for y < 16384.
  localparam int unsigned         RECIP_W     = 13;
  localparam logic [RECIP_W-1:0]  RECIP_100   = 13'd5243;
  localparam int unsigned         RECIP_SHIFT = 19;
  localparam int unsigned         CENT_W      = 7;    // quotient and remainder, 0..99
  localparam logic [CENT_W-1:0]   CENT_LAST   = 7'd99;
  localparam logic [CENT_W-1:0]   CENT_SIZE   = 7'd100;

  // Length of a month; month is already clamped to 1..12.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Year counter commands from the sequencer.
  typedef struct packed {
    logic load;   // capture a fresh start year
    logic div;    // register the quotient by 100
    logic rem;    // register the remainder by 100
    logic inc;    // advance one year
  } year_ctl_t;

  // Result of one month step.
  typedef struct packed {
    logic             fits;   // day lies within the current month
    logic [RUN_W-1:0] left;   // day minus the month length
  } step_res_t;

endpackage

// ===== hw/rtl/dad_if.sv =====
// Valid/ready channel interfaces for date_add_days input and result beats.
interface dad_in_if;
  import dad_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   start_day;
  logic [MONTH_W-1:0] start_month;
  logic [YEAR_W-1:0]  start_year;
  logic [COUNT_W-1:0] add_count;
  modport source (output valid, start_day, start_month, start_year, add_count,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, add_count,
                output ready);
endinterface

interface dad_out_if;
  import dad_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   end_day;
  logic [MONTH_W-1:0] end_month;
  logic [YEAR_W-1:0]  end_year;
  logic               year_overflow;
  modport source (output valid, end_day, end_month, end_year, year_overflow,
                  input ready);
  modport sink (input valid, end_day, end_month, end_year, year_overflow,
                output ready);
endinterface

// ===== hw/rtl/dad_step_unit.sv =====
// Shared month step: looks up the month length, compares and subtracts.
module dad_step_unit
  import dad_pkg::*;
(
  input  logic [RUN_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic               leap,
  output step_res_t          res
);

  logic [DAY_W-1:0] len;

  assign len      = month_len(month, leap);
  assign res.fits = (day <= RUN_W'(len));
  assign res.left = day - RUN_W'(len);

endmodule

// ===== hw/rtl/dad_year_ctr.sv =====
// Year register with running residues mod 4, mod 100 and century mod 4.
module dad_year_ctr
  import dad_pkg::*;
(
  input  logic              clk,
  input  logic [YEAR_W-1:0] load_year,
  input  year_ctl_t         ctl,
  output logic [YEAR_W-1:0] year,
  output logic              leap,
  output logic              at_max
);

  localparam int unsigned PROD_W = YEAR_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [CENT_W-1:0] cent;       // year / 100
  logic [YEAR_W-1:0] cent_x100;
  logic [CENT_W-1:0] mod100;
  logic [1:0]        cent_mod4;

  assign prod      = PROD_W'(year) * PROD_W'(RECIP_100);
  assign cent_x100 = YEAR_W'(cent) * YEAR_W'(CENT_SIZE);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      year <= load_year;
    end else if (ctl.div) begin
      cent <= prod[RECIP_SHIFT +: CENT_W];
    end else if (ctl.rem) begin
      mod100    <= CENT_W'(year - cent_x100);
      cent_mod4 <= cent[1:0];
    end else if (ctl.inc) begin
      year <= year + YEAR_W'(1);
      if (mod100 == CENT_LAST) begin
        mod100    <= '0;
        cent_mod4 <= cent_mod4 + 2'd1;
      end else begin
        mod100 <= mod100 + CENT_W'(1);
      end
    end
  end

  assign leap   = (year[1:0] == 2'd0) && ((mod100 != '0) || (cent_mod4 == 2'd0));
  assign at_max = (year >= YEAR_MAX);

endmodule

// ===== hw/rtl/date_add_days.sv =====
// Top level of date_add_days: input clamp, month-step sequencer, result register.
//
// Adds add_count days to a Gregorian date. A start beat is clamped (day 0 to 1,
// month into 1..12, year into 1..9999), then the sequencer splits the year by
// 100 for the leap rule in ST_DIV and ST_REM and afterwards walks forward one
// month per cycle through a single shared compare-and-subtract unit.
// in_ch.ready is high only while the sequencer is idle; the result sits in
// an output register, so a new beat may be taken while the previous result
// still waits for out_ch.ready. If the year would pass 9999, the walk stops
// and the result is 31 December 9999 with year_overflow set.
module date_add_days
  import dad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dad_in_if.sink    in_ch,
  dad_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_REM  = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [RUN_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic               leap, at_max;
  logic               accept, can_post, finish;
  year_ctl_t          yctl;
  step_res_t          step;

  // Clamped start fields.
  logic [DAY_W-1:0]   d0;
  logic [MONTH_W-1:0] m0;
  logic [YEAR_W-1:0]  y0;

  assign d0 = (in_ch.start_day == '0) ? DAY_W'(1) : in_ch.start_day;
  assign m0 = (in_ch.start_month == '0)      ? MONTH_JAN :
              (in_ch.start_month > MONTH_DEC) ? MONTH_DEC : in_ch.start_month;
  assign y0 = (in_ch.start_year == '0)      ? YEAR_MIN :
              (in_ch.start_year > YEAR_MAX) ? YEAR_MAX : in_ch.start_year;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // The result register is free when empty or being drained this cycle.
  assign can_post    = !out_ch.valid || out_ch.ready;

  dad_step_unit u_step (
    .day   (day),
    .month (month),
    .leap  (leap),
    .res   (step)
  );

  dad_year_ctr u_year (
    .clk       (clk),
    .load_year (y0),
    .ctl       (yctl),
    .year      (year),
    .leap      (leap),
    .at_max    (at_max)
  );

  // Finish when the day fits or the year would wrap past the last one.
  assign finish = (state == ST_RUN) &&
                  (step.fits || ((month == MONTH_DEC) && at_max));

  always_comb begin
    yctl      = '0;
    yctl.load = accept;
    yctl.div  = (state == ST_DIV);
    yctl.rem  = (state == ST_REM);
    yctl.inc  = (state == ST_RUN) && !finish && (month == MONTH_DEC);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DIV;
      ST_DIV:  state_next = ST_REM;
      ST_REM:  state_next = ST_RUN;
      ST_RUN:  if (finish && can_post) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running day and month; hold while the result register is blocked.
  always_ff @(posedge clk) begin
    if (accept) begin
      day   <= RUN_W'(d0) + RUN_W'(in_ch.add_count);
      month <= m0;
    end else if ((state == ST_RUN) && !finish) begin
      day   <= step.left;
      month <= (month == MONTH_DEC) ? MONTH_JAN : month + MONTH_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (finish && can_post) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && can_post) begin
      if (step.fits) begin
        out_ch.end_day       <= DAY_W'(day);
        out_ch.end_month     <= month;
        out_ch.end_year      <= year;
        out_ch.year_overflow <= 1'b0;
      end else begin
        out_ch.end_day       <= DAY_LAST;
        out_ch.end_month     <= MONTH_DEC;
        out_ch.end_year      <= YEAR_MAX;
        out_ch.year_overflow <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dad_checker.sv =====
// Port-level checker for date_add_days and its bind.
module dad_checker
  import dad_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DAY_W-1:0]   end_day,
  input logic [MONTH_W-1:0] end_month,
  input logic [YEAR_W-1:0]  end_year,
  input logic               year_overflow
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(end_day) && $stable(end_month)
      && $stable(end_year) && $stable(year_overflow))
    else $error("result beat changed while stalled");

  // Busy right after taking a beat.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting a beat");

  // A new result only appears at the end of a walk.
  a_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // Overflow saturates to the last day.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && year_overflow |-> end_day == DAY_LAST && end_month == MONTH_DEC
      && end_year == YEAR_MAX)
    else $error("overflow result not saturated");

  // Result is a normalized date.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_day != '0 && end_month != '0 && end_month <= MONTH_DEC
      && end_year != '0 && end_year <= YEAR_MAX)
    else $error("result date out of range");

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .end_day       (out_ch.end_day),
  .end_month     (out_ch.end_month),
  .end_year      (out_ch.end_year),
  .year_overflow (out_ch.year_overflow)
);

// ===== sim/tb.sv =====
// Testbench for date_add_days: directed and random date sums checked against a calendar walk.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dad_pkg::*;

  // Expected result of one beat, laid out like the output channel.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               ovf;
  } date_res_t;

  localparam int unsigned RANDOM_DATES = 241;
  localparam int unsigned CALM_DATES   = 70;         // opening random beats with no idling
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2200;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dad_in_if  in_ch();
  dad_out_if out_ch();

  date_add_days u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Dates accepted by the block whose results have not come back yet, oldest first.
  date_res_t   due_dates[$];
  int unsigned dates_sent     = 0;
  int unsigned dates_checked  = 0;
  int unsigned overflows_seen = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;   // no idling on either side while set
  bit          sink_held      = 1'b0;   // result side held off by the hold process
  event        hold_go;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Days in a month under the Gregorian leap rule.
  function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
    logic leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mon)
      32'(MONTH_FEB): return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Clamp the start date, add the count, then walk forward a month at a time.
  function automatic date_res_t shift_date(input logic [DAY_W-1:0]   d,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [YEAR_W-1:0]  y,
                                           input logic [COUNT_W-1:0] n);
    int unsigned day, mon, yr, len;
    logic        walking;
    date_res_t   r;
    day = (d == '0) ? 1 : 32'(d);
    mon = (m == '0) ? 32'(MONTH_JAN) : ((m > MONTH_DEC) ? 32'(MONTH_DEC) : 32'(m));
    yr  = (y == '0) ? 32'(YEAR_MIN) : ((y > YEAR_MAX) ? 32'(YEAR_MAX) : 32'(y));
    day = day + 32'(n);
    r.ovf   = 1'b0;
    walking = 1'b1;
    while (walking) begin
      len = month_days(mon, yr);
      if (day <= len) begin
        walking = 1'b0;
      end else begin
        day = day - len;
        mon++;
        if (mon > 32'(MONTH_DEC)) begin
          mon = 32'(MONTH_JAN);
          // Stop at the end of year 9999 instead of rolling into 10000.
          if (yr >= 32'(YEAR_MAX)) begin
            r.ovf   = 1'b1;
            day     = 32'(DAY_LAST);
            mon     = 32'(MONTH_DEC);
            yr      = 32'(YEAR_MAX);
            walking = 1'b0;
          end else begin
            yr++;
          end
        end
      end
    end
    r.day   = DAY_W'(day);
    r.month = MONTH_W'(mon);
    r.year  = YEAR_W'(yr);
    return r;
  endfunction

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string text);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycle_count, text);
  endtask

  // Offer one date beat. Drive on the falling edge, idle at random first, and
  // hold the beat until a rising edge sees ready. Valid is left high so the
  // next beat can follow back to back.
  task automatic send_date(input logic [DAY_W-1:0]   d,
                           input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0]  y,
                           input logic [COUNT_W-1:0] n);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.start_day   <= d;
    in_ch.start_month <= m;
    in_ch.start_year  <= y;
    in_ch.add_count   <= n;
    in_ch.valid       <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due_dates.push_back(shift_date(d, m, y, n));
    dates_sent++;
  endtask

  // Drop valid once a run of beats is over so nothing is offered twice.
  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Clamping of every field, month ends, leap rules, year wrap and overflow.
  task automatic test_calendar_edges();
    send_date(5'd1,  4'd1,  14'd1,     16'd0);       // earliest date, nothing added
    send_date(5'd0,  4'd3,  14'd2020,  16'd0);       // day zero reads as the first
    send_date(5'd15, 4'd0,  14'd2000,  16'd0);       // month zero reads as January
    send_date(5'd5,  4'd13, 14'd2000,  16'd0);       // month past December clamps
    send_date(5'd9,  4'd15, 14'd1999,  16'd0);
    send_date(5'd1,  4'd1,  14'd0,     16'd0);       // year zero reads as year one
    send_date(5'd10, 4'd6,  14'd16383, 16'd0);       // year all ones clamps to 9999
    send_date(5'd31, 4'd4,  14'd2021,  16'd0);       // day past the end of April
    send_date(5'd31, 4'd2,  14'd2021,  16'd0);       // February 31 carries into March
    send_date(5'd28, 4'd2,  14'd2024,  16'd1);       // plain leap year
    send_date(5'd28, 4'd2,  14'd1900,  16'd1);       // century, not a leap year
    send_date(5'd28, 4'd2,  14'd2000,  16'd1);       // every fourth century leaps
    send_date(5'd30, 4'd6,  14'd2023,  16'd1);       // June has 30 days
    send_date(5'd30, 4'd11, 14'd2023,  16'd1);       // November has 30 days
    send_date(5'd31, 4'd12, 14'd1999,  16'd1);       // year wrap
    send_date(5'd1,  4'd1,  14'd1,     16'hFFFF);    // largest count
    send_date(5'd31, 4'd12, 14'd9998,  16'd365);     // lands exactly on the last day
    send_date(5'd31, 4'd12, 14'd9999,  16'd0);       // last day, no overflow
    send_date(5'd31, 4'd12, 14'd9999,  16'd1);       // one day past the last
    send_date(5'd1,  4'd1,  14'd9990,  16'hFFFF);    // overflow partway through
    send_date(5'd31, 4'd15, 14'd16383, 16'hFFFF);    // every field at its top
    release_input();
  endtask

  // Mostly well-formed dates with random counts, plus out-of-range noise.
  // Years lean toward centuries and the last decades before the overflow.
  task automatic test_random_dates();
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [COUNT_W-1:0] n;
    int unsigned        pick;
    bit                 noisy;
    for (int i = 0; i < RANDOM_DATES; i++) begin
      calm  = (i < CALM_DATES);
      noisy = ($urandom_range(0, 99) < 15);
      pick  = $urandom_range(0, 99);
      if (noisy) begin
        y = YEAR_W'($urandom_range(0, 16383));
        m = MONTH_W'($urandom_range(0, 15));
        d = DAY_W'($urandom_range(0, 31));
      end else begin
        if (pick < 60) begin
          y = YEAR_W'($urandom_range(1, 9999));
        end else if (pick < 78) begin
          y = YEAR_W'($urandom_range(9960, 9999));
        end else begin
          y = YEAR_W'(100 * $urandom_range(1, 99) - $urandom_range(0, 1));
        end
        m = MONTH_W'($urandom_range(1, 12));
        d = DAY_W'($urandom_range(1, month_days(32'(m), 32'(y))));
      end
      // Keep most walks short; a few run the full count range.
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        n = COUNT_W'($urandom_range(0, 800));
      end else if (pick < 88) begin
        n = COUNT_W'($urandom_range(0, 20000));
      end else if (pick < 96) begin
        n = COUNT_W'($urandom_range(0, 65535));
      end else begin
        n = 16'hFFFF - COUNT_W'($urandom_range(0, 15));
      end
      send_date(d, m, y, n);
    end
    calm = 1'b0;
    release_input();
  endtask

  // Hold the result side off while beats keep coming, so the output register
  // fills and the block has to refuse input until the hold ends.
  task automatic test_output_backpressure();
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    -> hold_go;
    for (int i = 0; i < 8; i++) begin
      m = MONTH_W'($urandom_range(1, 12));
      y = YEAR_W'($urandom_range(1, 9999));
      send_date(DAY_W'($urandom_range(1, month_days(32'(m), 32'(y)))), m, y,
                COUNT_W'($urandom_range(0, 40)));
    end
    release_input();
  endtask

  // Count the hold in cycles here; the ready driver just reads the flag.
  always begin
    @(hold_go);
    sink_held = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_held = 1'b0;
  end

  // Drive result-side ready on the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= !sink_held && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check each result beat against the oldest due date, field by field.
  always @(posedge clk) begin
    date_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d/%0d ovf %0b with nothing due",
                                  out_ch.end_day, out_ch.end_month, out_ch.end_year,
                                  out_ch.year_overflow));
      end else begin
        want = due_dates.pop_front();
        dates_checked++;
        if (want.ovf) overflows_seen++;
        if (out_ch.end_day !== want.day) begin
          report_mismatch($sformatf("end_day %0d, expected %0d", out_ch.end_day, want.day));
        end
        if (out_ch.end_month !== want.month) begin
          report_mismatch($sformatf("end_month %0d, expected %0d",
                                    out_ch.end_month, want.month));
        end
        if (out_ch.end_year !== want.year) begin
          report_mismatch($sformatf("end_year %0d, expected %0d",
                                    out_ch.end_year, want.year));
        end
        if (out_ch.year_overflow !== want.ovf) begin
          report_mismatch($sformatf("year_overflow %0b, expected %0b",
                                    out_ch.year_overflow, want.ovf));
        end
      end
    end
  end

  // Advance the cycle count and stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still due", cycle_count,
               due_dates.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Hold every input at a known value until the first falling edge.
    in_ch.valid       = 1'b0;
    in_ch.start_day   = '0;
    in_ch.start_month = '0;
    in_ch.start_year  = '0;
    in_ch.add_count   = '0;
    out_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_calendar_edges();
    test_random_dates();
    test_output_backpressure();

    // Wait for every due date, then give a stray result time to show up.
    while (due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d date sums, %0d of them past year 9999, in %0d cycles,",
             dates_checked, dates_sent, overflows_seen, cycle_count);
    $display("with clamped fields, leap rules, random idling and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
